[hw/rtl/sha1_pkg.sv]
// sha1_pkg: shared types, constants and helpers for the SHA-1 digest block.
// Used by sha1_round and sha1_message_digest; depends on nothing.
`default_nettype none

package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] chain_t;

  localparam int unsigned ROUNDS = 80;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } sha1_state_t;

  // control from the sequencer to the round unit
  typedef struct packed {
    logic       push;
    logic       load;
    logic       step;
    logic [6:0] round;
    word_t      push_word;
  } rnd_ctl_t;

  function automatic chain_t init_chain();
    chain_t c;
    c[0] = 32'h67452301;
    c[1] = 32'hEFCDAB89;
    c[2] = 32'h98BADCFE;
    c[3] = 32'h10325476;
    c[4] = 32'hC3D2E1F0;
    return c;
  endfunction

  function automatic word_t round_const(input logic [1:0] stage);
    word_t k;
    case (stage)
      2'd0:    k = 32'h5A827999;
      2'd1:    k = 32'h6ED9EBA1;
      2'd2:    k = 32'h8F1BBCDC;
      default: k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sha1_round.sv]
// sha1_round: 16-word message schedule window and the a..e round registers.
// One SHA-1 round per step; depends on sha1_pkg.
`default_nettype none

module sha1_round (
  input  logic              clk,
  input  sha1_pkg::rnd_ctl_t ctl,
  input  sha1_pkg::chain_t  chain,
  output sha1_pkg::chain_t  work
);

  sha1_pkg::word_t  w_r [16];
  sha1_pkg::chain_t work_r;

  sha1_pkg::word_t a, b, c, d, e;
  sha1_pkg::word_t mix, sched, f, t_sum;
  logic [1:0]      stage;

  always_comb begin
    a = work_r[0];
    b = work_r[1];
    c = work_r[2];
    d = work_r[3];
    e = work_r[4];
    // w_r[0] holds W[t]; next word of the window is W[t+16]
    mix   = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    sched = {mix[30:0], mix[31]};
    if (ctl.round < 7'd20) begin
      stage = 2'd0;
    end else if (ctl.round < 7'd40) begin
      stage = 2'd1;
    end else if (ctl.round < 7'd60) begin
      stage = 2'd2;
    end else begin
      stage = 2'd3;
    end
    case (stage)
      2'd0:    f = d ^ (b & (c ^ d));
      2'd2:    f = (b & c) | (d & (b | c));
      default: f = b ^ c ^ d;
    endcase
    t_sum = {a[26:0], a[31:27]} + f + e + sha1_pkg::round_const(stage) + w_r[0];
  end

  always_ff @(posedge clk) begin
    if (ctl.push || ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= ctl.push ? ctl.push_word : sched;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work_r <= chain;
    end else if (ctl.step) begin
      work_r[0] <= t_sum;
      work_r[1] <= a;
      work_r[2] <= {b[1:0], b[31:2]};
      work_r[3] <= c;
      work_r[4] <= d;
    end
  end

  assign work = work_r;

endmodule

`default_nettype wire

[hw/rtl/sha1_message_digest.sv]
// sha1_message_digest: byte-stream SHA-1 hasher, top level.
// Depends on sha1_pkg and sha1_round.
//
// Usage:
//   Input channel (in_valid/in_ready): one beat per message byte; in_has_byte
//   qualifies in_data_byte, in_end_of_message marks the final beat (it may
//   carry no byte). A beat with neither byte nor end mark is a no-op.
//   Output channel (out_valid/out_ready): five beats per message, H0..H4,
//   out_digest_last set on H4.
//   Input: while idle, the block takes a new beat every cycle. The beat that
//   completes a 64-byte block is followed by a compression (80 rounds of the
//   single round unit plus one chaining add) during which in_ready is low.
//   Final beat: pad words go in one per cycle (up to 16), then one or two
//   compressions, then H0..H4 are loaded into the output register one by one.
//   The output register parts the two sides: after H4 is loaded the block is
//   ready for the next message while H4 still waits. A stalled receiver
//   holds the current digest beat and the sequencer waits for it.
//   Reset (synchronous, rst_n low) loads the initial chaining values,
//   clears the byte count and drops out_valid.
`default_nettype none

module sha1_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic        out_digest_last
);

  sha1_pkg::sha1_state_t state_r, state_nxt;

  logic [6:0]       round_r, round_nxt;
  logic [3:0]       wcnt_r, wcnt_nxt;
  logic             padfirst_r, padfirst_nxt;
  logic             lenok_r, lenok_nxt;
  logic             pend_r, pend_nxt;
  logic             padblk_r, padblk_nxt;
  logic [60:0]      bcnt_r, bcnt_nxt;
  logic [23:0]      acc_r, acc_nxt;
  sha1_pkg::chain_t chain_r, chain_nxt;
  logic [2:0]       oidx_r, oidx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_word_r, out_word_nxt;
  logic             out_last_r, out_last_nxt;

  sha1_pkg::rnd_ctl_t ctl;
  sha1_pkg::chain_t   work;

  logic            in_fire;
  logic            byte_fire;
  logic            blk_done;
  logic            out_load;
  logic [63:0]     bits;
  sha1_pkg::word_t pad_word;
  sha1_pkg::word_t fill_word;

  assign in_fire   = in_valid && in_ready;
  assign byte_fire = in_fire && in_has_byte;
  assign blk_done  = byte_fire && (bcnt_r[5:0] == 6'd63);
  assign out_load  = (state_r == sha1_pkg::ST_OUT) && (!out_valid_r || out_ready);
  assign bits      = {bcnt_r, 3'b000};

  always_comb begin
    case (bcnt_r[1:0])
      2'd0:    pad_word = {sha1_pkg::PAD_BYTE, 24'h0};
      2'd1:    pad_word = {acc_r[7:0], sha1_pkg::PAD_BYTE, 16'h0};
      2'd2:    pad_word = {acc_r[15:0], sha1_pkg::PAD_BYTE, 8'h0};
      default: pad_word = {acc_r, sha1_pkg::PAD_BYTE};
    endcase
    if (padfirst_r) begin
      fill_word = pad_word;
    end else if (lenok_r && wcnt_r == 4'd14) begin
      fill_word = bits[63:32];
    end else if (lenok_r && wcnt_r == 4'd15) begin
      fill_word = bits[31:0];
    end else begin
      fill_word = '0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (blk_done) begin
          state_nxt = sha1_pkg::ST_COMP;
        end else if (in_fire && in_end_of_message) begin
          state_nxt = sha1_pkg::ST_PAD;
        end
      end
      sha1_pkg::ST_PAD: begin
        if (wcnt_r == 4'd15) begin
          state_nxt = sha1_pkg::ST_COMP;
        end
      end
      sha1_pkg::ST_COMP: begin
        if (round_r == 7'(sha1_pkg::ROUNDS - 1)) begin
          state_nxt = sha1_pkg::ST_ADD;
        end
      end
      sha1_pkg::ST_ADD: begin
        if (pend_r) begin
          state_nxt = sha1_pkg::ST_PAD;
        end else if (padblk_r) begin
          state_nxt = lenok_r ? sha1_pkg::ST_OUT : sha1_pkg::ST_PAD;
        end else begin
          state_nxt = sha1_pkg::ST_IDLE;
        end
      end
      sha1_pkg::ST_OUT: begin
        if (out_load && oidx_r == 3'd4) begin
          state_nxt = sha1_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha1_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready      = 1'b0;
    ctl.push      = 1'b0;
    ctl.load      = 1'b0;
    ctl.step      = 1'b0;
    ctl.round     = round_r;
    ctl.push_word = fill_word;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (byte_fire && bcnt_r[1:0] == 2'd3) begin
          ctl.push      = 1'b1;
          ctl.push_word = {acc_r, in_data_byte};
        end
        ctl.load = blk_done;
      end
      sha1_pkg::ST_PAD: begin
        ctl.push = 1'b1;
        ctl.load = (wcnt_r == 4'd15);
      end
      sha1_pkg::ST_COMP: begin
        ctl.step = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_comb begin
    round_nxt     = round_r;
    wcnt_nxt      = wcnt_r;
    padfirst_nxt  = padfirst_r;
    lenok_nxt     = lenok_r;
    pend_nxt      = pend_r;
    padblk_nxt    = padblk_r;
    bcnt_nxt      = bcnt_r;
    acc_nxt       = acc_r;
    chain_nxt     = chain_r;
    oidx_nxt      = oidx_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (byte_fire) begin
          bcnt_nxt = bcnt_r + 61'd1;
          acc_nxt  = {acc_r[15:0], in_data_byte};
        end
        if (blk_done) begin
          pend_nxt   = in_end_of_message;
          padblk_nxt = 1'b0;
        end else if (in_fire && in_end_of_message) begin
          wcnt_nxt     = bcnt_nxt[5:2];
          padfirst_nxt = 1'b1;
          lenok_nxt    = (bcnt_nxt[5:3] != 3'd7);
        end
      end
      sha1_pkg::ST_PAD: begin
        wcnt_nxt     = wcnt_r + 4'd1;
        padfirst_nxt = 1'b0;
        pend_nxt     = 1'b0;
        padblk_nxt   = 1'b1;
      end
      sha1_pkg::ST_COMP: begin
        round_nxt = (round_r == 7'(sha1_pkg::ROUNDS - 1)) ? 7'd0 : round_r + 7'd1;
      end
      sha1_pkg::ST_ADD: begin
        for (int i = 0; i < 5; i++) begin
          chain_nxt[i] = chain_r[i] + work[i];
        end
        // a pending final mark starts padding on a fresh block
        if (pend_r) begin
          wcnt_nxt     = 4'd0;
          padfirst_nxt = 1'b1;
          lenok_nxt    = 1'b1;
        end else if (padblk_r && !lenok_r) begin
          wcnt_nxt     = 4'd0;
          padfirst_nxt = 1'b0;
          lenok_nxt    = 1'b1;
        end
      end
      sha1_pkg::ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = chain_r[oidx_r];
          out_last_nxt  = (oidx_r == 3'd4);
          if (oidx_r == 3'd4) begin
            oidx_nxt  = 3'd0;
            chain_nxt = sha1_pkg::init_chain();
            bcnt_nxt  = '0;
          end else begin
            oidx_nxt = oidx_r + 3'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1_pkg::ST_IDLE;
      round_r     <= '0;
      wcnt_r      <= '0;
      padfirst_r  <= 1'b0;
      lenok_r     <= 1'b0;
      pend_r      <= 1'b0;
      padblk_r    <= 1'b0;
      bcnt_r      <= '0;
      chain_r     <= sha1_pkg::init_chain();
      oidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      wcnt_r      <= wcnt_nxt;
      padfirst_r  <= padfirst_nxt;
      lenok_r     <= lenok_nxt;
      pend_r      <= pend_nxt;
      padblk_r    <= padblk_nxt;
      bcnt_r      <= bcnt_nxt;
      chain_r     <= chain_nxt;
      oidx_r      <= oidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  sha1_round u_round (
    .clk   (clk),
    .ctl   (ctl),
    .chain (chain_r),
    .work  (work)
  );

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_digest_last = out_last_r;

`ifndef SYNTHESIS
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1_pkg::ST_COMP) |-> (round_r < 7'(sha1_pkg::ROUNDS)))
    else $error("round counter out of range");

  a_idle_oidx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1_pkg::ST_IDLE) |-> (oidx_r == 3'd0))
    else $error("digest index not cleared in idle");

  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_end_of_message) |=> !in_ready)
    else $error("ready right after final beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=>
      (out_valid_r && $stable(out_word_r) && $stable(out_last_r)))
    else $error("digest beat changed while stalled");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
// testbench: self-checking bench for sha1_message_digest (byte-stream SHA-1).
// A clocked driver feeds message beats from a queue and a clocked monitor checks
// each digest beat against a built-in SHA-1 predictor. Needs only the RTL.
`default_nettype none

module testbench;

  typedef struct {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
    logic       hold;     // not a beat: sender waits for all digests to drain
  } msg_beat_t;

  typedef struct {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_PAR = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_PR2 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam int          RND_ITEMS = 380;
  localparam int          DRAIN_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_has_byte = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic        out_digest_last;

  sha1_message_digest DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_digest_last   (out_digest_last)
  );

  msg_beat_t    pending[$];
  digest_beat_t digest_q[$];
  msg_beat_t    cur_beat;
  int           beats_queued = 0;
  int           beats_taken = 0;
  int           words_seen = 0;
  int           fail_cnt = 0;

  // predictor state
  logic [31:0] chain_h [0:4];
  logic [7:0]  blk [0:63];
  logic [60:0] msg_len;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 400000);
    $display("TB_ERROR");
    $finish;
  end

  task automatic restart_chain();
    chain_h[0] = 32'h67452301;
    chain_h[1] = 32'hEFCDAB89;
    chain_h[2] = 32'h98BADCFE;
    chain_h[3] = 32'h10325476;
    chain_h[4] = 32'hC3D2E1F0;
    msg_len = '0;
  endtask

  task automatic compress_blk();
    logic [31:0] w [0:79];
    logic [31:0] a, b, c, d, e, f, k, t;
    int r;
    for (r = 0; r < 16; r++)
      w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    for (r = 16; r < 80; r++) begin
      t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {t[30:0], t[31]};
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = d ^ (b & (c ^ d));
        k = K_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_PAR;
      end else if (r < 60) begin
        f = (b & c) | (d & (b | c));
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_PR2;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endtask

  // fold one accepted beat into the running hash; queue the digest on the end mark
  task automatic hash_beat(input msg_beat_t mb);
    int pos, i;
    logic [63:0] bit_len;
    digest_beat_t db;
    if (mb.has_byte) begin
      blk[msg_len[5:0]] = mb.data;
      msg_len = msg_len + 61'd1;
      if (msg_len[5:0] == 6'd0)
        compress_blk();
    end
    if (mb.eom) begin
      pos = int'(msg_len[5:0]);
      blk[pos] = PAD_MARK;
      for (i = pos + 1; i < 64; i++)
        blk[i] = 8'h00;
      if (pos >= 56) begin
        compress_blk();
        for (i = 0; i < 64; i++)
          blk[i] = 8'h00;
      end
      bit_len = {msg_len, 3'b000};
      for (i = 0; i < 8; i++)
        blk[56+i] = bit_len[63-8*i -: 8];
      compress_blk();
      for (i = 0; i < 5; i++) begin
        db.word = chain_h[i];
        db.last = (i == 4);
        digest_q.push_back(db);
      end
      restart_chain();
    end
  endtask

  task automatic queue_beat(input logic [7:0] data, input logic has, input logic eom);
    msg_beat_t mb;
    mb.data = data;
    mb.has_byte = has;
    mb.eom = eom;
    mb.hold = 1'b0;
    pending.push_back(mb);
    beats_queued++;
  endtask

  task automatic queue_hold();
    msg_beat_t mb;
    mb.data = 8'h00;
    mb.has_byte = 1'b0;
    mb.eom = 1'b0;
    mb.hold = 1'b1;
    pending.push_back(mb);
  endtask

  // random message of len bytes; returns the number of beats queued
  task automatic queue_message(input int len, output int n_beats);
    int i;
    logic tail_empty;
    tail_empty = (len == 0) || ($urandom_range(1) == 1);
    n_beats = 0;
    for (i = 0; i < len; i++) begin
      // noise: empty beats without end mark, data ignored
      if ($urandom_range(9) == 0) begin
        queue_beat(8'($urandom_range(255)), 1'b0, 1'b0);
        n_beats++;
      end
      queue_beat(8'($urandom_range(255)), 1'b1, !tail_empty && (i == len - 1));
      n_beats++;
    end
    if (tail_empty) begin
      queue_beat(8'($urandom_range(255)), 1'b0, 1'b1);
      n_beats++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'h00;
      in_has_byte <= 1'b0;
      in_end_of_message <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hash_beat(cur_beat);
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending.size() != 0 && pending[0].hold) begin
          in_valid <= 1'b0;
          if (digest_q.size() == 0)
            void'(pending.pop_front());
        end else if (pending.size() != 0 &&
                     ((beats_taken >= 150 && beats_taken < 300) ||
                      $urandom_range(99) >= 21)) begin
          cur_beat = pending.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= cur_beat.data;
          in_has_byte <= cur_beat.has_byte;
          in_end_of_message <= cur_beat.eom;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (digest_q.size() == 0) begin
          $error("unexpected digest beat: digest_word %h digest_last %b",
                 out_digest_word, out_digest_last);
          fail_cnt++;
        end else begin
          exp_beat = digest_q.pop_front();
          if (out_digest_word !== exp_beat.word) begin
            $error("digest_word: expected %h, got %h", exp_beat.word, out_digest_word);
            fail_cnt++;
          end
          if (out_digest_last !== exp_beat.last) begin
            $error("digest_last: expected %b, got %b", exp_beat.last, out_digest_last);
            fail_cnt++;
          end
        end
      end
      out_ready <= (words_seen >= 20 && words_seen < 60) || ($urandom_range(99) >= 21);
    end
  end

  initial begin
    int len, n_beats, rnd_items;
    logic mid_hold;
    restart_chain();
    for (int i = 0; i < 64; i++)
      blk[i] = 8'h00;
    rnd_items = 0;
    mid_hold = 1'b0;

    // directed: empty message
    queue_beat(8'h00, 1'b0, 1'b1);
    // "abc", end mark on the last byte
    queue_beat(8'h61, 1'b1, 1'b0);
    queue_beat(8'h62, 1'b1, 1'b0);
    queue_beat(8'h63, 1'b1, 1'b1);
    // ignored bytes and no-op beats around real bytes, closed by an empty final beat
    queue_beat(8'hFF, 1'b0, 1'b0);
    queue_beat(8'h00, 1'b1, 1'b0);
    queue_beat(8'h5A, 1'b0, 1'b0);
    queue_beat(8'hFF, 1'b1, 1'b0);
    queue_beat(8'hA5, 1'b0, 1'b1);
    // single-byte messages with end mark, extremes of data, then a two-byte message
    queue_beat(8'hFF, 1'b1, 1'b1);
    queue_beat(8'h00, 1'b1, 1'b1);
    queue_beat(8'h00, 1'b1, 1'b0);
    queue_beat(8'h80, 1'b1, 1'b1);
    // empty final beat with a set data byte
    queue_beat(8'hFF, 1'b0, 1'b1);
    queue_hold();

    // random messages, lengths biased to the padding boundaries
    while (rnd_items < RND_ITEMS) begin
      case ($urandom_range(9))
        0, 1, 2, 3: len = $urandom_range(12);
        4, 5, 6:    len = 55 + $urandom_range(10);
        7:          len = 118 + $urandom_range(11);
        default:    len = $urandom_range(130);
      endcase
      queue_message(len, n_beats);
      rnd_items += n_beats;
      if (!mid_hold && rnd_items >= RND_ITEMS / 2) begin
        queue_hold();
        mid_hold = 1'b1;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_taken != beats_queued)
      @(posedge clk);
    while (digest_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0 && digest_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
